/* rtl/upd_pkg.sv */
`default_nettype none

package upd_pkg;

    localparam int unsigned CODE_COUNT = 35;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    typedef struct packed {
        logic       found;
        logic [7:0] value;
    } t_lookup;

    // first code char, second code char, decoded byte
    localparam logic [23:0] CODE_TABLE [CODE_COUNT] = '{
        {"2", "0", 8'h20}, {"2", "1", 8'h21}, {"2", "2", 8'h22}, {"2", "3", 8'h23},
        {"2", "4", 8'h24}, {"2", "5", 8'h25}, {"2", "6", 8'h26}, {"2", "7", 8'h27},
        {"2", "8", 8'h28}, {"2", "9", 8'h29}, {"2", "A", 8'h2A}, {"2", "B", 8'h2B},
        {"2", "C", 8'h2C}, {"2", "D", 8'h2D}, {"2", "E", 8'h2E},
        {"3", "A", 8'h3A}, {"3", "B", 8'h3B}, {"3", "C", 8'h3C}, {"3", "D", 8'h3D},
        {"3", "E", 8'h3E}, {"3", "F", 8'h3F}, {"4", "0", 8'h40},
        {"5", "B", 8'h5B}, {"5", "C", 8'h5C}, {"5", "D", 8'h5D}, {"5", "E", 8'h5E},
        {"5", "F", 8'h5F}, {"6", "0", 8'h60},
        {"7", "B", 8'h7B}, {"7", "C", 8'h7C}, {"7", "D", 8'h7D}, {"7", "E", 8'h7E},
        {"0", "A", 8'h0A}, {"0", "D", 8'h0D}, {"0", "9", 8'h09}
    };

    function automatic t_lookup lookup_code(input logic [7:0] hi, input logic [7:0] lo);
        t_lookup res;
        res.found = 1'b0;
        res.value = 8'h00;
        for (int i = 0; i < CODE_COUNT; i++) begin
            if (CODE_TABLE[i][23:16] == hi && CODE_TABLE[i][15:8] == lo) begin
                res.found = 1'b1;
                res.value = CODE_TABLE[i][7:0];
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/url_percent_decoder.sv */
// An accepted input word goes through the input register, then the result register.
// Throughput: one input word per cycle unless a result waits on a stalled output;
// a word that gives no result takes no output slot. An input register and a result
// register part the two sides, so input is taken while a result waits to be read.
// Reset (i_rst_n, synchronous, active low) clears the escape state and both valid flags.
`default_nettype none

module url_percent_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  wire logic       i_s_axis_tlast,
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]      o_m_axis_tuser,   // [0] byte_valid, [1] unknown_code
    output logic            o_m_axis_tlast
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    logic       r_esc;
    logic       r_held;
    logic [7:0] r_first;
    logic       n_esc;
    logic       n_held;
    logic [7:0] n_first;

    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic       r_out_bvalid;
    logic       r_out_unknown;
    logic       r_out_last;

    logic       w_valid;
    logic       w_unknown;
    logic [7:0] w_byte;
    logic       w_emit;
    logic       w_adv;
    upd_pkg::t_lookup w_look;

    assign w_look = upd_pkg::lookup_code(r_first, r_in_byte);

    always_comb begin
        n_esc     = r_esc;
        n_held    = r_held;
        n_first   = r_first;
        w_valid   = 1'b0;
        w_unknown = 1'b0;
        w_byte    = 8'h00;
        priority if (r_in_byte == upd_pkg::PCT_CHAR) begin
            n_esc = 1'b1;
        end else if (r_in_byte == upd_pkg::PLUS_CHAR) begin
            w_valid = 1'b1;
            w_byte  = upd_pkg::SPACE_CHAR;
        end else if (r_esc) begin
            if (!r_held) begin
                n_first = r_in_byte;
                n_held  = 1'b1;
            end else begin
                w_valid   = 1'b1;
                w_byte    = w_look.found ? w_look.value : upd_pkg::SPACE_CHAR;
                w_unknown = !w_look.found;
                n_esc     = 1'b0;
                n_held    = 1'b0;
                n_first   = 8'h00;
            end
        end else begin
            w_valid = 1'b1;
            w_byte  = r_in_byte;
        end
        // drop any partial escape at end of string
        if (r_in_last) begin
            n_esc   = 1'b0;
            n_held  = 1'b0;
            n_first = 8'h00;
        end
    end

    assign w_emit = w_valid || r_in_last;
    assign w_adv  = r_in_valid && (!w_emit || !r_out_valid || i_m_axis_tready);

    assign o_s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc   <= 1'b0;
            r_held  <= 1'b0;
            r_first <= 8'h00;
        end else if (w_adv) begin
            r_esc   <= n_esc;
            r_held  <= n_held;
            r_first <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out_data    <= w_byte;
            r_out_bvalid  <= w_valid;
            r_out_unknown <= w_unknown;
            r_out_last    <= r_in_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = {r_out_unknown, r_out_bvalid};
    assign o_m_axis_tlast  = r_out_last;

    a_held_needs_escape : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held |-> r_esc)
        else $error("code byte held without a pending escape");

    a_last_clears_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_in_last |=> !r_esc && !r_held && r_first == 8'h00)
        else $error("escape state survives end of string");

    a_unknown_is_space : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1]
        |-> o_m_axis_tuser[0] && o_m_axis_tdata == upd_pkg::SPACE_CHAR)
        else $error("unknown code without a space result");

    a_empty_is_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0]
        |-> o_m_axis_tlast && o_m_axis_tdata == 8'h00 && !o_m_axis_tuser[1])
        else $error("result without a byte that does not end the string");

endmodule

`default_nettype wire
